FILE: sv/qrb_pkg.sv
`default_nettype none
// ============================================================================
// qrb_pkg: shared types and constants for the quartic root finder
// Holds the request and result structs, the status codes and the sequencer
// states.
// ============================================================================
package qrb_pkg;

    localparam int unsigned MaxSteps = 32;
    localparam int unsigned FracBits = 16;
    localparam int unsigned WordBits = 32;
    localparam int unsigned TolBits  = 31;
    localparam logic [TolBits-1:0] TolReset = 31'd655;

    typedef struct packed {
        logic signed [31:0] coefficient_a;
        logic signed [31:0] coefficient_b;
        logic signed [31:0] coefficient_c;
        logic signed [31:0] coefficient_d;
        logic signed [31:0] coefficient_e;
        logic signed [31:0] point_0;
        logic signed [31:0] point_1;
        logic signed [31:0] point_2;
        logic signed [31:0] point_3;
        logic signed [31:0] point_4;
    } t_request;

    typedef struct packed {
        logic signed [31:0] root;
        logic [2:0]         status;
    } t_result;

    typedef enum logic [2:0] {
        ST_BISECTED = 3'd0,
        ST_FIRST    = 3'd1,
        ST_ALL_POS  = 3'd2,
        ST_NO_NEG   = 3'd3,
        ST_BAD      = 3'd4,
        ST_CAP      = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_ADD,
        S_EVAL_DONE,
        S_DECIDE,
        S_MID,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: sv/quartic_root_bisection.sv
`default_nettype none
// ============================================================================
// quartic_root_bisection: fixed-point quartic root finder by bisection
// Evaluates the quartic at five bracket points and bisects the first sign
// change with one shared 32 by 32 multiplier, one Horner step at a time.
// ============================================================================
// A request is taken when i_start is high and o_busy is low. The block then
// stays busy and gives exactly one result, on o_result for one cycle with
// o_done high. The receiver cannot stall. The tolerance register is written
// on its own channel when i_cfg_valid and o_cfg_ready are both high; it is
// ready whenever the block is idle.
// Each Horner step runs S_MUL_LO and S_MUL_HI on the shared multiplier (low
// and high half of the accumulator times the point), then S_ADD to shift,
// saturate and add. An evaluation is four steps plus a record state
// (S_EVAL_DONE) and a decision state (S_DECIDE). The five point evaluations
// come first, and each midpoint is formed in S_MID before it is evaluated.
// A new request is taken only after the result strobe, once the block is
// back in S_IDLE. Reset returns the block to idle and the tolerance to 655.
module quartic_root_bisection #(
    parameter int unsigned MAX_STEPS = qrb_pkg::MaxSteps
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire qrb_pkg::t_request i_request,
    output logic                  o_busy,
    output logic                  o_done,
    output qrb_pkg::t_result      o_result,
    input  wire logic             i_cfg_valid,
    input  wire logic [qrb_pkg::TolBits-1:0] i_cfg_data,
    output logic                  o_cfg_ready
);

    localparam int unsigned SW = $clog2(MAX_STEPS + 1);
    localparam logic signed [63:0] Sat = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int unsigned FB = qrb_pkg::FracBits;

    qrb_pkg::t_state r_state, n_state;
    qrb_pkg::t_request r_req;
    logic [qrb_pkg::TolBits-1:0] r_tol;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_x;
    logic [95:0] r_prod;
    logic        r_neg;
    logic [1:0]  r_hstep;
    logic [2:0]  r_pidx;
    logic        r_bisect;
    logic [SW-1:0] r_steps;
    logic signed [63:0] r_y [5];
    logic signed [31:0] r_lo, r_hi;
    logic signed [63:0] r_flo;
    logic signed [31:0] r_root;
    logic [2:0]  r_status;

    logic [63:0] mag_a, mul_p;
    logic [31:0] mag_x, mul_a;
    logic [79:0] q;
    logic signed [63:0] prod_s, coef, sum, absfm;
    logic signed [64:0] wide_sum;
    logic signed [31:0] pt_next, lo_sel, hi_sel, mid;
    logic [32:0] diff;
    logic [2:0] sel;
    logic found, all_pos, first_hit, bad, hit, cap, finish_scan;

    assign o_result.root   = r_root;
    assign o_result.status = r_status;

    always_comb begin
        mag_a = r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
        mag_x = r_x[31] ? 32'(-r_x) : 32'(r_x);
        mul_a = (r_state == qrb_pkg::S_MUL_HI) ? mag_a[63:32] : mag_a[31:0];
        mul_p = mul_a * mag_x;
    end

    always_comb begin
        q = 80'(r_prod >> FB);
        if (q > 80'(Sat)) begin
            prod_s = r_neg ? -Sat : Sat;
        end else begin
            prod_s = r_neg ? -$signed(q[63:0]) : $signed(q[63:0]);
        end
        unique case (r_hstep)
            2'd0: coef = 64'(r_req.coefficient_b);
            2'd1: coef = 64'(r_req.coefficient_c);
            2'd2: coef = 64'(r_req.coefficient_d);
            default: coef = 64'(r_req.coefficient_e);
        endcase
        wide_sum = 65'(prod_s) + 65'(coef);
        if (wide_sum > 65'(Sat)) begin
            sum = Sat;
        end else if (wide_sum < -65'(Sat)) begin
            sum = -Sat;
        end else begin
            sum = wide_sum[63:0];
        end
    end

    always_comb begin
        unique case (r_pidx)
            3'd0: pt_next = r_req.point_1;
            3'd1: pt_next = r_req.point_2;
            3'd2: pt_next = r_req.point_3;
            default: pt_next = r_req.point_4;
        endcase
        diff  = 33'(r_hi) - 33'(r_lo);
        mid   = r_lo + $signed(diff[32:1]);
        absfm = r_acc[63] ? -r_acc : r_acc;
        hit   = $unsigned(absfm) < 64'(r_tol);
        cap   = (r_steps == SW'(MAX_STEPS));
        found = 1'b0;
        sel = 3'd0;
        for (int i = 4; i >= 1; i--) begin
            if (r_y[i] < 0) begin
                found = 1'b1;
                sel = 3'(i);
            end
        end
        unique case (sel)
            3'd1: begin
                lo_sel = r_req.point_0;
                hi_sel = r_req.point_1;
            end
            3'd2: begin
                lo_sel = r_req.point_1;
                hi_sel = r_req.point_2;
            end
            3'd3: begin
                lo_sel = r_req.point_2;
                hi_sel = r_req.point_3;
            end
            default: begin
                lo_sel = r_req.point_3;
                hi_sel = r_req.point_4;
            end
        endcase
        first_hit   = (r_y[0] <= 0);
        all_pos     = (r_y[1] > 0) && (r_y[2] > 0) && (r_y[3] > 0) && (r_y[4] > 0);
        bad         = (lo_sel > hi_sel);
        finish_scan = first_hit || all_pos || !found || bad;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qrb_pkg::S_IDLE:      if (i_start) n_state = qrb_pkg::S_MUL_LO;
            qrb_pkg::S_MUL_LO:    n_state = qrb_pkg::S_MUL_HI;
            qrb_pkg::S_MUL_HI:    n_state = qrb_pkg::S_ADD;
            qrb_pkg::S_ADD:       n_state = (r_hstep == 2'd3) ? qrb_pkg::S_EVAL_DONE
                                                              : qrb_pkg::S_MUL_LO;
            qrb_pkg::S_EVAL_DONE: n_state = qrb_pkg::S_DECIDE;
            qrb_pkg::S_DECIDE: begin
                if (!r_bisect) begin
                    priority if (r_pidx != 3'd4) begin
                        n_state = qrb_pkg::S_MUL_LO;
                    end else if (finish_scan) begin
                        n_state = qrb_pkg::S_DONE;
                    end else begin
                        n_state = qrb_pkg::S_MID;
                    end
                end else begin
                    n_state = (hit || cap) ? qrb_pkg::S_DONE : qrb_pkg::S_MID;
                end
            end
            qrb_pkg::S_MID:       n_state = qrb_pkg::S_MUL_LO;
            qrb_pkg::S_DONE:      n_state = qrb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_busy      = (r_state != qrb_pkg::S_IDLE);
        o_cfg_ready = (r_state == qrb_pkg::S_IDLE);
        o_done      = (r_state == qrb_pkg::S_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= qrb_pkg::S_IDLE;
            r_tol    <= qrb_pkg::TolReset;
            r_steps  <= '0;
            r_root   <= '0;
            r_status <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_tol <= i_cfg_data;
            unique case (r_state)
                qrb_pkg::S_IDLE: if (i_start) begin
                    r_req    <= i_request;
                    r_acc    <= 64'(i_request.coefficient_a);
                    r_x      <= i_request.point_0;
                    r_hstep  <= 2'd0;
                    r_pidx   <= 3'd0;
                    r_bisect <= 1'b0;
                    r_steps  <= '0;
                end
                qrb_pkg::S_MUL_LO: begin
                    r_prod <= 96'(mul_p);
                    r_neg  <= r_acc[63] != r_x[31];
                end
                qrb_pkg::S_MUL_HI: begin
                    r_prod <= r_prod + {mul_p, 32'd0};
                end
                qrb_pkg::S_ADD: begin
                    r_acc   <= sum;
                    r_hstep <= r_hstep + 2'd1;
                end
                qrb_pkg::S_EVAL_DONE: begin
                    if (!r_bisect) r_y[r_pidx] <= r_acc;
                end
                qrb_pkg::S_DECIDE: begin
                    if (!r_bisect) begin
                        priority if (r_pidx != 3'd4) begin
                            r_pidx  <= r_pidx + 3'd1;
                            r_acc   <= 64'(r_req.coefficient_a);
                            r_x     <= pt_next;
                            r_hstep <= 2'd0;
                        end else if (first_hit) begin
                            r_root <= r_req.point_0; r_status <= qrb_pkg::ST_FIRST;
                        end else if (all_pos) begin
                            r_root <= '1; r_status <= qrb_pkg::ST_ALL_POS;
                        end else if (!found) begin
                            r_root <= '0; r_status <= qrb_pkg::ST_NO_NEG;
                        end else if (bad) begin
                            r_root <= '1; r_status <= qrb_pkg::ST_BAD;
                        end else begin
                            r_lo     <= lo_sel;
                            r_hi     <= hi_sel;
                            r_flo    <= r_y[sel - 3'd1];
                            r_bisect <= 1'b1;
                        end
                    end else begin
                        priority if (hit) begin
                            r_status <= qrb_pkg::ST_BISECTED;
                        end else if (cap) begin
                            r_status <= qrb_pkg::ST_CAP;
                        end else if (r_flo[63] != r_acc[63]) begin
                            r_hi <= r_root;
                        end else begin
                            r_lo  <= r_root;
                            r_flo <= r_acc;
                        end
                    end
                end
                qrb_pkg::S_MID: begin
                    r_x     <= mid;
                    r_root  <= mid;
                    r_acc   <= 64'(r_req.coefficient_a);
                    r_hstep <= 2'd0;
                    r_steps <= r_steps + SW'(1);
                end
                qrb_pkg::S_DONE: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy)
        else $error("done not followed by idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request not taken");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.status <= qrb_pkg::ST_CAP)
        else $error("bad status");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> r_steps <= SW'(MAX_STEPS))
        else $error("step count overrun");

endmodule
`default_nettype wire
